// ===== rtl/core/cfws_pkg.sv =====
// ----------------------------------------------------------------------------
// cfws_pkg
// shared types and codes for the circular fifo with search
// ----------------------------------------------------------------------------
package cfws_pkg;

   localparam int WORD_W = 32;

   typedef enum logic [1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_SEARCH  = 2'd2,
      CMD_CLEAR   = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_INDEX = 3'd1,
      STATUS_EMPTY     = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   // what a storage cell does in one cycle
   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_LOAD  = 2'd1,
      CELL_SHIFT = 2'd2,
      CELL_WRAP  = 2'd3
   } cell_op_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_SCAN = 1'b1
   } fsm_state_type;

endpackage

// ===== rtl/core/cfws_cell.sv =====
// ----------------------------------------------------------------------------
// cfws_cell
// one word of the queue: holds, loads a new word, takes its neighbor's word
// or takes the front word when the queue rotates
// ----------------------------------------------------------------------------
module cfws_cell import cfws_pkg::*; (
   input  logic              clock,
   input  cell_op_type       op,
   input  logic [WORD_W-1:0] load_word,
   input  logic [WORD_W-1:0] next_word,
   input  logic [WORD_W-1:0] head_word,
   output logic [WORD_W-1:0] word
);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      case (op)
         CELL_HOLD:  word_in = word_ff;
         CELL_LOAD:  word_in = load_word;
         CELL_SHIFT: word_in = next_word;
         CELL_WRAP:  word_in = head_word;
         default:    word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// ===== rtl/core/circular_fifo_with_search_core.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_with_search_core
// fifo of signed words with index-checked enqueue/dequeue, search and clear
// ----------------------------------------------------------------------------
// The queue lives in a chain of DEPTH cells, cell 0 always holding the front
// word. An enqueue writes the cell at the current count, a dequeue shifts the
// whole chain one cell toward the front. Every command gives exactly one
// result transfer carrying a status and the count after the command. A
// transfer on req_ lands in a one-entry command register; enqueue, dequeue
// and clear complete from that register once the result register is free,
// and a new transfer is taken as the held one retires, so with no back
// pressure one command is taken every cycle. A search rotates the occupied
// cells one place per cycle past a comparator on cell 0 until the queue is
// back in order, blocking further commands meanwhile. The result sits in an
// output register; the next command is taken while it waits on rsp_stall.
// Stored words have no reset; reset clears only the count and control.
// ----------------------------------------------------------------------------
module circular_fifo_with_search_core import cfws_pkg::*; #(
   parameter int DEPTH = 64,
   localparam int CNT_W = $clog2(DEPTH + 1),
   localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   // command channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_command,
   input  logic [CNT_W-1:0]         req_position_request,
   input  logic signed [WORD_W-1:0] req_value,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_status,
   output logic signed [WORD_W-1:0] rsp_removed_word,
   output logic [POS_W-1:0]         rsp_found_position,
   output logic [CNT_W-1:0]         rsp_occupancy
);

   // command register
   logic              item_valid_ff, item_valid_in;
   command_type       item_cmd_ff, item_cmd_in;
   logic [CNT_W-1:0]  item_pos_ff, item_pos_in;
   logic [WORD_W-1:0] item_value_ff, item_value_in;

   // queue control
   fsm_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   logic              hit_ff, hit_in;
   logic [POS_W-1:0]  hit_pos_ff, hit_pos_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic              req_take;
   logic              out_free;
   logic              item_done;
   logic              do_enqueue;
   logic              do_dequeue;
   logic              do_rotate;

   // cell chain
   logic [WORD_W-1:0] cell_word [DEPTH];
   cell_op_type       cell_op   [DEPTH];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = item_valid_ff && !item_done;
   assign req_take  = req_valid && !req_stall;

   // ---- command sequencing ----
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      hit_in        = hit_ff;
      hit_pos_in    = hit_pos_ff;
      item_done     = 1'b0;
      do_enqueue    = 1'b0;
      do_dequeue    = 1'b0;
      do_rotate     = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         FSM_IDLE: begin
            if (item_valid_ff) begin
               if (item_cmd_ff == CMD_SEARCH) begin
                  // start a full rotation of the occupied cells
                  state_in = FSM_SCAN;
                  step_in  = '0;
                  hit_in   = 1'b0;
               end else if (out_free) begin
                  item_done     = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_word_in   = '0;
                  rsp_pos_in    = '0;
                  case (item_cmd_ff)
                     CMD_ENQUEUE: begin
                        // index is checked before fullness
                        if (item_pos_ff != count_ff) begin
                           rsp_status_in = STATUS_BAD_INDEX;
                        end else if (count_ff == CNT_W'(DEPTH)) begin
                           rsp_status_in = STATUS_FULL;
                        end else begin
                           do_enqueue = 1'b1;
                           count_in   = count_ff + 1'b1;
                        end
                     end
                     CMD_DEQUEUE: begin
                        // emptiness is checked before the index
                        if (count_ff == '0) begin
                           rsp_status_in = STATUS_EMPTY;
                        end else if (item_pos_ff != '0) begin
                           rsp_status_in = STATUS_BAD_INDEX;
                        end else begin
                           do_dequeue  = 1'b1;
                           rsp_word_in = cell_word[0];
                           count_in    = count_ff - 1'b1;
                        end
                     end
                     CMD_CLEAR: begin
                        count_in = '0;
                     end
                     default: begin
                        rsp_status_in = STATUS_OK;
                     end
                  endcase
                  rsp_count_in = count_in;
               end
            end
         end
         FSM_SCAN: begin
            if (step_ff != count_ff) begin
               // compare the front word, then rotate it to the back
               do_rotate = 1'b1;
               step_in   = step_ff + 1'b1;
               if (!hit_ff && (cell_word[0] == item_value_ff)) begin
                  hit_in     = 1'b1;
                  hit_pos_in = step_ff[POS_W-1:0];
               end
            end else if (out_free) begin
               // rotation complete: queue is back in order
               item_done     = 1'b1;
               state_in      = FSM_IDLE;
               rsp_status_in = hit_ff ? STATUS_OK : STATUS_NOT_FOUND;
               rsp_word_in   = '0;
               rsp_pos_in    = hit_ff ? hit_pos_ff : '0;
               rsp_count_in  = count_ff;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // command register accepts a new transfer in the cycle the old one retires
   always_comb begin
      item_valid_in = req_take || (item_valid_ff && !item_done);
      item_cmd_in   = item_cmd_ff;
      item_pos_in   = item_pos_ff;
      item_value_in = item_value_ff;
      if (req_take) begin
         item_cmd_in   = command_type'(req_command);
         item_pos_in   = req_position_request;
         item_value_in = req_value;
      end
   end

   // result register: a new result loads whenever a command retires
   assign rsp_valid_in = item_done || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         state_ff      <= FSM_IDLE;
         count_ff      <= '0;
         step_ff       <= '0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         state_ff      <= state_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
         hit_ff        <= hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      item_cmd_ff   <= item_cmd_in;
      item_pos_ff   <= item_pos_in;
      item_value_ff <= item_value_in;
      hit_pos_ff    <= hit_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // ---- cell chain ----
   // enqueue loads the cell at the count, dequeue shifts every cell forward,
   // a rotation step shifts forward and drops the front word into the last
   // occupied cell
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] neighbor_word;

      if (i < DEPTH - 1) begin : g_inner
         assign neighbor_word = cell_word[i+1];
      end else begin : g_last
         assign neighbor_word = cell_word[0];
      end

      always_comb begin
         cell_op[i] = CELL_HOLD;
         if (do_enqueue && (count_ff == CNT_W'(i))) begin
            cell_op[i] = CELL_LOAD;
         end else if (do_dequeue) begin
            cell_op[i] = CELL_SHIFT;
         end else if (do_rotate) begin
            cell_op[i] = (count_ff == CNT_W'(i + 1)) ? CELL_WRAP : CELL_SHIFT;
         end
      end

      cfws_cell u_cell (
         .clock     (clock),
         .op        (cell_op[i]),
         .load_word (item_value_ff),
         .next_word (neighbor_word),
         .head_word (cell_word[0]),
         .word      (cell_word[i])
      );
   end

   // ---- outputs ----
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_removed_word   = rsp_word_ff;
   assign rsp_found_position = rsp_pos_ff;
   assign rsp_occupancy      = rsp_count_ff;

   // ---- assertions ----
   // the count never passes the capacity
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fifo count above capacity");

   // a rotation never runs past the occupied cells
   a_scan_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_SCAN) |-> (step_ff <= count_ff))
      else $error("search rotation overran the count");

   // a search in progress always has its command held
   a_scan_has_item : assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_SCAN) |-> item_valid_ff)
      else $error("search running without a held command");

   // a search never changes the count
   a_scan_keeps_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_SCAN) |=> (count_ff == $past(count_ff)))
      else $error("count changed during a search");

endmodule
